@@ rtl/stereo_noise_gate_core_defines.svh @@
// Assertion macros shared by the stereo noise gate RTL.
// Define ASSERT_OFF to compile the assertions out; no other dependencies.
`ifndef STEREO_NOISE_GATE_CORE_DEFINES_SVH
`define STEREO_NOISE_GATE_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// Property that must hold at every clock edge out of reset
`define SNC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Condition in one cycle implies a condition in the next
`define SNC_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`else
`define SNC_ASSERT(lbl, clk, rstn, prop, msg)
`define SNC_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)
`endif
`endif

@@ rtl/snc_pkg.sv @@
// Shared constants for the stereo noise gate: register indexes, reset values and queue sizing.
// No dependencies.
package snc_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MONO      = 2'd3;

    // Register reset values
    localparam int THRESHOLD_RESET = 83886;
    localparam int ATTACK_RESET    = 1351;
    localparam int RELEASE_RESET   = 27;

    // Queue between the detector and the gain stage
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

endpackage

@@ rtl/stereo_noise_gate_core.sv @@
// Stereo noise gate core with attack/release envelope.
// Input channel s_*: one stereo frame per transfer (s_left_in, s_right_in), valid/ready.
// Result channel m_*: one gated frame per input frame (m_left_out, m_right_out,
//   m_gate_level), valid/ready, in input order.
// Configuration: cfg_we writes cfg_wdata into register cfg_index at the clock edge:
//   0 threshold level, 1 attack coefficient, 2 release coefficient, 3 mono mode.
//   Write only while no frame is in flight.
// Path: a frame accepted on s_* is written into the queue, then into the envelope
//   stage registers, then into the output register that drives m_*.
// Throughput: one frame per cycle while m_ready is high; the envelope recurrence
//   (one multiply, add and clamp) closes in its stage; scaling sits in the next.
// A two-entry queue parts the detector from the gain stage; the output register
//   parts the gain stage from the receiver. When m_ready is low the result holds,
//   the pipeline and queue fill, and s_ready drops once the queue is full.
// Reset (aresetn low, synchronous) closes the gate (envelope zero), empties the
//   queue and pipeline, and restores the register reset values.
module stereo_noise_gate_core #(
    parameter int SAMPLE_BITS    = 24,
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_we,
    input  logic [snc_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [((SAMPLE_BITS > GAIN_FRAC_BITS + 1) ?
                   SAMPLE_BITS : GAIN_FRAC_BITS + 1)-1:0] cfg_wdata,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [SAMPLE_BITS-1:0]          s_left_in,
    input  logic signed [SAMPLE_BITS-1:0]          s_right_in,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [SAMPLE_BITS-1:0]          m_left_out,
    output logic signed [SAMPLE_BITS-1:0]          m_right_out,
    output logic        [GAIN_FRAC_BITS:0]         m_gate_level
);

    localparam int GW = GAIN_FRAC_BITS + 1;
    localparam int QW = 2 * SAMPLE_BITS + 2;

    logic [SAMPLE_BITS-1:0] threshold_reg;
    logic [GW-1:0]          attack_reg;
    logic [GW-1:0]          release_reg;
    logic                   mono_reg;

    logic          fq_valid, fq_ready;
    logic [QW-1:0] fq_data;
    logic          qb_valid, qb_ready;
    logic [QW-1:0] qb_data;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= SAMPLE_BITS'(snc_pkg::THRESHOLD_RESET);
            attack_reg    <= GW'(snc_pkg::ATTACK_RESET);
            release_reg   <= GW'(snc_pkg::RELEASE_RESET);
            mono_reg      <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                snc_pkg::CFG_THRESHOLD: threshold_reg <= cfg_wdata[SAMPLE_BITS-1:0];
                snc_pkg::CFG_ATTACK:    attack_reg    <= cfg_wdata[GW-1:0];
                snc_pkg::CFG_RELEASE:   release_reg   <= cfg_wdata[GW-1:0];
                snc_pkg::CFG_MONO:      mono_reg      <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    snc_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_left_in       (s_left_in),
        .s_right_in      (s_right_in),
        .threshold_level (threshold_reg),
        .mono_mode       (mono_reg),
        .q_valid         (fq_valid),
        .q_ready         (fq_ready),
        .q_data          (fq_data)
    );

    snc_queue #(
        .WIDTH (QW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    snc_back #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (qb_valid),
        .q_ready       (qb_ready),
        .q_data        (qb_data),
        .attack_coeff  (attack_reg),
        .release_coeff (release_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_left_out    (m_left_out),
        .m_right_out   (m_right_out),
        .m_gate_level  (m_gate_level)
    );

endmodule

@@ rtl/snc_front.sv @@
// Detector front end: takes in stereo frames, forms the magnitude and the gate target,
// and pushes the classified frame into the queue. Depends on nothing else.
module snc_front #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_left_in,
    input  logic signed [SAMPLE_BITS-1:0] s_right_in,
    input  logic        [SAMPLE_BITS-1:0] threshold_level,
    input  logic                          mono_mode,
    output logic                          q_valid,
    input  logic                          q_ready,
    output logic        [2*SAMPLE_BITS+1:0] q_data
);

    logic [SAMPLE_BITS-1:0] abs_left;
    logic [SAMPLE_BITS-1:0] abs_right;
    logic [SAMPLE_BITS-1:0] magnitude;
    logic                   target_open;

    // Absolute values; the most negative sample maps to full scale as unsigned
    assign abs_left  = s_left_in[SAMPLE_BITS-1]  ? (~s_left_in + 1'b1)  : s_left_in;
    assign abs_right = s_right_in[SAMPLE_BITS-1] ? (~s_right_in + 1'b1) : s_right_in;

    // Pick the detector magnitude, left only in mono
    always_comb begin
        magnitude = abs_left;
        if (!mono_mode && (abs_right > abs_left)) begin
            magnitude = abs_right;
        end
    end

    assign target_open = (magnitude >= threshold_level);

    // Pass the frame on with its classification
    assign q_valid = s_valid;
    assign s_ready = q_ready;
    assign q_data  = {mono_mode, target_open, s_right_in, s_left_in};

endmodule

@@ rtl/snc_queue.sv @@
// Two-entry queue between the detector front end and the gain back end.
// Depends on snc_pkg for depth and pointer widths.
module snc_queue #(
    parameter int WIDTH = 50
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic [WIDTH-1:0]              entry_reg [snc_pkg::QUEUE_DEPTH];
    logic [snc_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [snc_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [snc_pkg::QCNT_W-1:0]    count_reg, count_next;
    logic                          push, pop;

    assign in_ready  = (count_reg != snc_pkg::QCNT_W'(snc_pkg::QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming entry
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

@@ rtl/snc_back.sv @@
// Gain back end: one-pole envelope update, then sample scaling into the output register.
// Depends on stereo_noise_gate_core_defines.svh for assertion macros.
`include "stereo_noise_gate_core_defines.svh"
module snc_back #(
    parameter int SAMPLE_BITS    = 24,
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            q_valid,
    output logic                            q_ready,
    input  logic        [2*SAMPLE_BITS+1:0] q_data,
    input  logic        [GAIN_FRAC_BITS:0]  attack_coeff,
    input  logic        [GAIN_FRAC_BITS:0]  release_coeff,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [SAMPLE_BITS-1:0]   m_left_out,
    output logic signed [SAMPLE_BITS-1:0]   m_right_out,
    output logic        [GAIN_FRAC_BITS:0]  m_gate_level
);

    localparam int GW = GAIN_FRAC_BITS + 1;
    localparam int PW = SAMPLE_BITS + GW + 1;
    localparam logic [GW-1:0] GAIN_ONE = GW'(1) << GAIN_FRAC_BITS;

    // Queue head fields
    logic signed [SAMPLE_BITS-1:0] head_left, head_right;
    logic                          head_target, head_mono;

    // Envelope stage
    logic [GW-1:0]          env_reg, env_next;
    logic                   attack;
    logic [GW-1:0]          coeff_raw, coeff_sat;
    logic signed [GW:0]     delta;
    logic signed [2*GW+1:0] env_prod, env_prod_sh;
    logic signed [GW+1:0]   env_step, env_sum;

    // Stage between envelope and scaling
    logic                          s1_valid_reg;
    logic signed [SAMPLE_BITS-1:0] s1_left_reg, s1_right_reg;
    logic                          s1_mono_reg;
    logic                          pop, s1_adv;

    // Scaling stage
    logic signed [PW-1:0]          left_prod, right_prod, left_sh, right_sh;
    logic signed [SAMPLE_BITS-1:0] left_gated, right_gated;
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] left_out_reg, right_out_reg;
    logic [GW-1:0]                 gate_out_reg;

    assign head_left   = q_data[SAMPLE_BITS-1:0];
    assign head_right  = q_data[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign head_target = q_data[2*SAMPLE_BITS];
    assign head_mono   = q_data[2*SAMPLE_BITS+1];

    // Handshake between stages
    assign s1_adv  = s1_valid_reg && (!out_valid_reg || m_ready);
    assign q_ready = !s1_valid_reg || s1_adv;
    assign pop     = q_valid && q_ready;

    // Envelope step toward the target, attack only when strictly below an open target
    always_comb begin
        attack      = head_target && (env_reg != GAIN_ONE);
        coeff_raw   = attack ? attack_coeff : release_coeff;
        coeff_sat   = (coeff_raw > GAIN_ONE) ? GAIN_ONE : coeff_raw;
        delta       = $signed({1'b0, (head_target ? GAIN_ONE : GW'(0))})
                      - $signed({1'b0, env_reg});
        env_prod    = delta * $signed({1'b0, coeff_sat});
        env_prod_sh = env_prod >>> GAIN_FRAC_BITS;
        env_step    = env_prod_sh[GW+1:0];
        env_sum     = $signed({2'b00, env_reg}) + env_step;
        if (env_sum[GW+1]) begin
            env_next = '0;
        end else if (env_sum[GW:0] > {1'b0, GAIN_ONE}) begin
            env_next = GAIN_ONE;
        end else begin
            env_next = env_sum[GW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            env_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                env_reg <= env_next;
            end
            if (q_ready) begin
                s1_valid_reg <= q_valid;
            end
        end
    end

    // Hold the frame while its envelope is applied
    always_ff @(posedge aclk) begin
        if (pop) begin
            s1_left_reg  <= head_left;
            s1_right_reg <= head_right;
            s1_mono_reg  <= head_mono;
        end
    end

    // Scale both samples by the new envelope, floor shift; in mono the right output copies the scaled left
    always_comb begin
        left_prod   = s1_left_reg * $signed({1'b0, env_reg});
        right_prod  = s1_right_reg * $signed({1'b0, env_reg});
        left_sh     = left_prod >>> GAIN_FRAC_BITS;
        right_sh    = right_prod >>> GAIN_FRAC_BITS;
        left_gated  = left_sh[SAMPLE_BITS-1:0];
        right_gated = s1_mono_reg ? left_sh[SAMPLE_BITS-1:0] : right_sh[SAMPLE_BITS-1:0];
    end

    // Output register, held while the receiver stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            left_out_reg  <= left_gated;
            right_out_reg <= right_gated;
            gate_out_reg  <= env_reg;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_left_out   = left_out_reg;
    assign m_right_out  = right_out_reg;
    assign m_gate_level = gate_out_reg;

    `SNC_ASSERT(a_env_bounded, aclk, aresetn, env_reg <= GAIN_ONE, "envelope above unity")
    `SNC_ASSERT_NEXT(a_attack_rises, aclk, aresetn, pop && head_target, env_reg >= $past(env_reg), "envelope fell on open target")
    `SNC_ASSERT_NEXT(a_release_falls, aclk, aresetn, pop && !head_target, env_reg <= $past(env_reg), "envelope rose on closed target")

endmodule
